FILE: rtl/wecq_pkg.sv
`timescale 1ns / 1ps

package wecq_pkg;

   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_FETCH  = 3'd1;
   localparam logic [2:0] KIND_QUERY  = 3'd2;
   localparam logic [2:0] KIND_CLEAR  = 3'd3;
   localparam logic [2:0] KIND_ACTION = 3'd4;

   localparam logic [1:0] ST_REL  = 2'd0;
   localparam logic [1:0] ST_DET  = 2'd1;
   localparam logic [1:0] ST_JDET = 2'd2;
   localparam logic [1:0] ST_JREL = 2'd3;

   localparam logic [2:0] ACT_NONE       = 3'd0;
   localparam logic [2:0] ACT_UP         = 3'd1;
   localparam logic [2:0] ACT_DOWN       = 3'd2;
   localparam logic [2:0] ACT_SHORT      = 3'd3;
   localparam logic [2:0] ACT_LONG       = 3'd4;
   localparam logic [2:0] ACT_CLICK_UP   = 3'd5;
   localparam logic [2:0] ACT_CLICK_DOWN = 3'd6;

   localparam logic [1:0] CSR_REVERSE    = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE   = 2'd1;
   localparam logic [1:0] CSR_LONG_PRESS = 2'd2;

   localparam logic [7:0]  DEBOUNCE_RESET   = 8'd50;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

   localparam logic [1:0] PH_ZERO  = 2'b00;
   localparam logic [1:0] PH_THREE = 2'b11;

   localparam logic signed [7:0] COUNT_MAX = 8'sd127;
   localparam logic signed [7:0] COUNT_MIN = -8'sd127;

   typedef struct packed {
      logic [2:0] kind;
      logic       phase_a;
      logic       phase_b;
      logic       button_down;
      logic       skip_scroll;
   } item_type;

   typedef struct packed {
      logic        reverse_direction;
      logic [7:0]  debounce_ticks;
      logic [15:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic signed [7:0] scroll_count;
      logic [1:0]        click_status;
      logic [2:0]        action;
      logic              activity;
   } result_type;

   // place of each phase state in the gray order 3,1,0,2
   function automatic logic [1:0] pos_of_state(input logic [1:0] st);
      logic [1:0] pos;
      case (st)
         2'd0: pos = 2'd2;
         2'd1: pos = 2'd1;
         2'd2: pos = 2'd3;
         default: pos = 2'd0;
      endcase
      return pos;
   endfunction

endpackage

FILE: rtl/wheel_encoder_click_qualifier_unit.sv
`timescale 1ns / 1ps

// scroll wheel detent counter and click qualifier
// request channel (req_*): one word per tick or software access, taken when
//   req_valid is high and req_stall low. kind picks tick, fetch count,
//   query click, clear or get action; ticks carry phase and button samples.
// response channel (rsp_*): one word for each fetch count, query click and
//   get action; ticks, clears and unknown kinds give none.
// csr channel: csr_index 0 reverse direction, 1 debounce ticks, 2 long press
//   ticks, written when csr_valid and csr_ready are high; csr_ready is always
//   high. write only while no request is in flight.
// a taken word waits in the input register until the output register can take
//   its response; the core then processes it and the response shows on rsp_*.
// throughput: one word per cycle while rsp_stall is low, set by the single input
//   register and the single output register.
// a stalled response holds in the output register; req_stall rises only
//   when the input register is full and the output register cannot drain.
// synchronous reset clears all counters, status and registers (debounce 50,
//   long press 1000) and empties both registers.

module wheel_encoder_click_qualifier_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_kind,
   input  logic              req_phase_a,
   input  logic              req_phase_b,
   input  logic              req_button_down,
   input  logic              req_skip_scroll,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_scroll_count,
   output logic [1:0]        rsp_click_status,
   output logic [2:0]        rsp_action,
   output logic              rsp_activity,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import wecq_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;

   logic       take;
   logic       advance;
   result_type core_res;
   logic       has_result;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_REVERSE:    cfg_in.reverse_direction = csr_data[0];
            CSR_DEBOUNCE:   cfg_in.debounce_ticks    = csr_data[7:0];
            CSR_LONG_PRESS: cfg_in.long_press_ticks  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_item_in  = '{kind: req_kind, phase_a: req_phase_a, phase_b: req_phase_b,
                         button_down: req_button_down, skip_scroll: req_skip_scroll};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_res_in   = out_res_ff;
      out_valid_in = out_valid_ff;
      if (advance && has_result) begin
         out_valid_in = 1'b1;
         out_res_in   = core_res;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{reverse_direction: 1'b0, debounce_ticks: DEBOUNCE_RESET,
                           long_press_ticks: LONG_PRESS_RESET};
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   wecq_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .item       (in_item_ff),
      .cfg        (cfg_ff),
      .res        (core_res),
      .has_result (has_result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_scroll_count = out_res_ff.scroll_count;
   assign rsp_click_status = out_res_ff.click_status;
   assign rsp_action       = out_res_ff.action;
   assign rsp_activity     = out_res_ff.activity;

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("input register lost a waiting word");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      advance && has_result |=> out_valid_ff)
      else $error("response not loaded into output register");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> in_valid_ff)
      else $error("accepted word did not reach the input register");

endmodule

FILE: rtl/wecq_core.sv
`timescale 1ns / 1ps

module wecq_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  wecq_pkg::item_type   item,
   input  wecq_pkg::cfg_type    cfg,
   output wecq_pkg::result_type res,
   output logic                has_result
);
   import wecq_pkg::*;

   logic signed [7:0] count_ff, count_in;
   logic [1:0]        last_pos_ff, last_pos_in;
   logic              armed_ff, armed_in;
   logic [7:0]        press_ff, press_in;
   logic [15:0]       hold_ff, hold_in;
   logic [1:0]        status_ff, status_in;
   logic              drop_ff, drop_in;

   logic [1:0]        st;
   logic [1:0]        pos;
   logic              fwd;
   logic              bwd;
   logic              step_up;
   logic [1:0]        s1;
   logic signed [7:0] cnt;
   logic              is_long;
   logic [2:0]        act;

   always_comb begin
      count_in    = count_ff;
      last_pos_in = last_pos_ff;
      armed_in    = armed_ff;
      press_in    = press_ff;
      hold_in     = hold_ff;
      status_in   = status_ff;
      drop_in     = drop_ff;
      res         = '0;
      has_result  = 1'b0;
      act         = ACT_NONE;

      st      = {item.phase_b, item.phase_a};
      pos     = pos_of_state(st);
      fwd     = (pos == last_pos_ff + 2'd1);
      bwd     = (pos == last_pos_ff - 2'd1);
      step_up = fwd ? cfg.reverse_direction : !cfg.reverse_direction;
      s1      = (status_ff == ST_JDET) ? ST_DET : status_ff;
      cnt     = item.skip_scroll ? 8'sd0 : count_ff;
      is_long = (hold_ff > cfg.long_press_ticks);

      case (item.kind)
         KIND_TICK: begin
            if (fwd || bwd) begin
               if (st == PH_ZERO) begin
                  armed_in = 1'b1;
               end else if (st == PH_THREE && armed_ff) begin
                  if (step_up) begin
                     if (count_ff != COUNT_MAX) count_in = count_ff + 8'sd1;
                  end else begin
                     if (count_ff != COUNT_MIN) count_in = count_ff - 8'sd1;
                  end
               end
               last_pos_in = pos;
            end
            if (item.button_down) begin
               if (press_ff == cfg.debounce_ticks && status_ff != ST_JREL) status_in = ST_JDET;
               if (press_ff != 8'hFF) press_in = press_ff + 8'd1;
               if ((status_in == ST_DET || status_in == ST_JDET) && hold_ff != 16'hFFFF)
                  hold_in = hold_ff + 16'd1;
            end else begin
               if (status_ff == ST_DET) begin
                  status_in = ST_JREL;
               end else if (status_ff != ST_JREL) begin
                  hold_in   = '0;
                  status_in = ST_REL;
               end
               press_in = '0;
            end
         end
         KIND_FETCH: begin
            has_result = 1'b1;
            if (count_ff != 8'sd0) begin
               res.scroll_count = count_ff;
               res.activity     = 1'b1;
               count_in         = '0;
            end
         end
         KIND_QUERY: begin
            has_result       = 1'b1;
            res.click_status = status_ff;
            if (status_ff == ST_JDET || status_ff == ST_JREL) begin
               res.activity = 1'b1;
               status_in    = (status_ff == ST_JDET) ? ST_DET : ST_REL;
            end
         end
         KIND_CLEAR: begin
            hold_in   = '0;
            status_in = ST_REL;
            count_in  = '0;
         end
         KIND_ACTION: begin
            has_result = 1'b1;
            status_in  = s1;
            if (s1 == ST_JREL || cnt != 8'sd0 || is_long) begin
               if (is_long) begin
                  act = ACT_LONG;
               end else if (s1 == ST_JREL) begin
                  if (cnt == 8'sd0) begin
                     if (drop_ff) drop_in = 1'b0;
                     else act = ACT_SHORT;
                  end
               end else if (s1 == ST_DET) begin
                  if (cnt > 8'sd0) act = ACT_CLICK_DOWN;
                  else if (cnt < 8'sd0) act = ACT_CLICK_UP;
               end else begin
                  if (cnt > 8'sd0) act = ACT_DOWN;
                  else if (cnt < 8'sd0) act = ACT_UP;
               end
               hold_in = '0;
               if (act != ACT_CLICK_DOWN && act != ACT_CLICK_UP) status_in = ST_REL;
               else drop_in = 1'b1;
               if (!item.skip_scroll) count_in = '0;
            end
            res.action   = act;
            res.activity = (act != ACT_NONE);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         last_pos_ff <= '0;
         armed_ff    <= 1'b0;
         press_ff    <= '0;
         hold_ff     <= '0;
         status_ff   <= ST_REL;
         drop_ff     <= 1'b0;
      end else if (step_en) begin
         count_ff    <= count_in;
         last_pos_ff <= last_pos_in;
         armed_ff    <= armed_in;
         press_ff    <= press_in;
         hold_ff     <= hold_in;
         status_ff   <= status_in;
         drop_ff     <= drop_in;
      end
   end

   a_clear_wipes: assert property (@(posedge clock) disable iff (reset)
      step_en && item.kind == KIND_CLEAR |=>
         hold_ff == 16'd0 && status_ff == ST_REL && count_ff == 8'sd0)
      else $error("clear left detections behind");

   a_query_acks: assert property (@(posedge clock) disable iff (reset)
      step_en && item.kind == KIND_QUERY |=> status_ff != ST_JDET && status_ff != ST_JREL)
      else $error("query did not acknowledge click status");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      step_en |=> count_ff != -8'sd128)
      else $error("detent count left its saturated range");

   a_arm_follows_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff && step_en && !(item.kind == KIND_TICK && st == PH_ZERO) |=> !armed_ff)
      else $error("counting armed without reaching the zero state");

endmodule

FILE: tb/sv/tb_wheel_encoder_click_qualifier_unit.sv
`timescale 1ns / 1ps

module tb_wheel_encoder_click_qualifier_unit;
   import wecq_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_kind = '0;
   logic              req_phase_a = 1'b0;
   logic              req_phase_b = 1'b0;
   logic              req_button_down = 1'b0;
   logic              req_skip_scroll = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [7:0] rsp_scroll_count;
   logic [1:0]        rsp_click_status;
   logic [2:0]        rsp_action;
   logic              rsp_activity;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [15:0]       csr_data = '0;

   wheel_encoder_click_qualifier_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_phase_a(req_phase_a),
      .req_phase_b(req_phase_b),
      .req_button_down(req_button_down),
      .req_skip_scroll(req_skip_scroll),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_scroll_count(rsp_scroll_count),
      .rsp_click_status(rsp_click_status),
      .rsp_action(rsp_action),
      .rsp_activity(rsp_activity),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // expected wheel and button state
   logic        cfg_reverse = 1'b0;
   logic [7:0]  cfg_debounce = DEBOUNCE_RESET;
   logic [15:0] cfg_long = LONG_PRESS_RESET;
   int          wh_count = 0;
   logic [1:0]  wh_place = '0;
   logic        wh_armed = 1'b0;
   logic [7:0]  btn_press = '0;
   logic [15:0] btn_hold = '0;
   logic [1:0]  btn_status = ST_REL;
   logic        btn_drop = 1'b0;

   item_type   word_backlog[$];
   result_type queued_readouts[$];
   item_type   drv_word = '0;
   logic       drv_have = 1'b0;
   int         gap_left = 0;
   int         stall_left = 0;
   bit         calm_send = 1'b0;
   bit         calm_recv = 1'b0;
   int         failures = 0;
   int         words_sent = 0;
   int         readouts_seen = 0;
   int         settings_used = 0;
   result_type want;

   // stimulus-side wheel walker and button run
   int gen_pos = 0;
   bit gen_fwd = 1'b1;
   bit gen_btn = 1'b0;
   int gen_run = 0;

   // phase levels at each place of the gray order 3,1,0,2
   function automatic logic [1:0] phase_at_place(input int place);
      case (place % 4)
         0: return PH_THREE;
         1: return 2'b01;
         2: return PH_ZERO;
         default: return 2'b10;
      endcase
   endfunction

   function automatic void wheel_tick(input logic a, input logic b, input logic btn);
      logic [1:0] st;
      logic [1:0] place;
      int         dir;
      st = {b, a};
      place = '0;
      dir = 0;
      for (int p = 0; p < 4; p++)
         if (phase_at_place(p) == st) place = 2'(p);
      if (place == wh_place + 2'd1) dir = cfg_reverse ? 1 : -1;
      else if (place == wh_place + 2'd3) dir = cfg_reverse ? -1 : 1;
      if (dir != 0) begin
         if (st == PH_ZERO) begin
            wh_armed = 1'b1;
         end else if (st == PH_THREE && wh_armed) begin
            wh_count = wh_count + dir;
            if (wh_count > COUNT_MAX) wh_count = COUNT_MAX;
            if (wh_count < COUNT_MIN) wh_count = COUNT_MIN;
         end
         wh_place = place;
      end
      if (btn) begin
         if (btn_press == cfg_debounce && btn_status != ST_JREL) btn_status = ST_JDET;
         if (btn_press != 8'hFF) btn_press++;
         if ((btn_status == ST_DET || btn_status == ST_JDET) && btn_hold != 16'hFFFF)
            btn_hold++;
      end else begin
         if (btn_status == ST_DET) begin
            btn_status = ST_JREL;
         end else if (btn_status != ST_JREL) begin
            btn_hold = '0;
            btn_status = ST_REL;
         end
         btn_press = '0;
      end
   endfunction

   function automatic logic [2:0] classify_action(input logic skip);
      int         cnt;
      logic [2:0] act;
      cnt = skip ? 0 : wh_count;
      act = ACT_NONE;
      if (btn_status == ST_JDET) btn_status = ST_DET;
      if (btn_status == ST_JREL || cnt != 0 || btn_hold > cfg_long) begin
         if (btn_hold > cfg_long) begin
            act = ACT_LONG;
         end else if (btn_status == ST_JREL) begin
            if (cnt == 0) begin
               if (btn_drop) btn_drop = 1'b0;
               else act = ACT_SHORT;
            end
         end else if (btn_status == ST_DET) begin
            if (cnt > 0) act = ACT_CLICK_DOWN;
            else if (cnt < 0) act = ACT_CLICK_UP;
         end else begin
            if (cnt > 0) act = ACT_DOWN;
            else if (cnt < 0) act = ACT_UP;
         end
         btn_hold = '0;
         if (act != ACT_CLICK_DOWN && act != ACT_CLICK_UP) btn_status = ST_REL;
         else btn_drop = 1'b1;
         if (!skip) wh_count = 0;
      end
      return act;
   endfunction

   function automatic void apply_word(input item_type w);
      result_type r;
      r = '0;
      case (w.kind)
         KIND_TICK: wheel_tick(w.phase_a, w.phase_b, w.button_down);
         KIND_FETCH: begin
            if (wh_count != 0) begin
               r.scroll_count = 8'(wh_count);
               r.activity = 1'b1;
               wh_count = 0;
            end
            queued_readouts.push_back(r);
         end
         KIND_QUERY: begin
            r.click_status = btn_status;
            if (btn_status == ST_JDET || btn_status == ST_JREL) begin
               r.activity = 1'b1;
               btn_status = (btn_status == ST_JDET) ? ST_DET : ST_REL;
            end
            queued_readouts.push_back(r);
         end
         KIND_CLEAR: begin
            btn_hold = '0;
            btn_status = ST_REL;
            wh_count = 0;
         end
         KIND_ACTION: begin
            r.action = classify_action(w.skip_scroll);
            r.activity = (r.action != ACT_NONE);
            queued_readouts.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_pause(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_have = 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_word(drv_word);
            words_sent++;
            drv_have = 1'b0;
            gap_left = pick_pause(calm_send);
         end
         if (!drv_have) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (word_backlog.size() != 0) begin
               drv_word = word_backlog.pop_front();
               drv_have = 1'b1;
            end
         end
         req_valid <= drv_have;
         req_kind <= drv_word.kind;
         req_phase_a <= drv_word.phase_a;
         req_phase_b <= drv_word.phase_b;
         req_button_down <= drv_word.button_down;
         req_skip_scroll <= drv_word.skip_scroll;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (queued_readouts.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unawaited word: count %0d status %0d action %0d activity %0d",
                           rsp_scroll_count, rsp_click_status, rsp_action, rsp_activity);
            end else begin
               want = queued_readouts.pop_front();
               readouts_seen++;
               if (rsp_scroll_count !== want.scroll_count ||
                   rsp_click_status !== want.click_status ||
                   rsp_action !== want.action || rsp_activity !== want.activity) begin
                  failures++;
                  if (failures <= 10)
                     $display("word %0d: expected count %0d status %0d action %0d activity %0d, got count %0d status %0d action %0d activity %0d",
                              readouts_seen, want.scroll_count, want.click_status,
                              want.action, want.activity, rsp_scroll_count,
                              rsp_click_status, rsp_action, rsp_activity);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_pause(calm_recv);
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_REVERSE: cfg_reverse = val[0];
         CSR_DEBOUNCE: cfg_debounce = val[7:0];
         CSR_LONG_PRESS: cfg_long = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic rev, input logic [7:0] deb, input logic [15:0] lp);
      write_reg(CSR_REVERSE, {15'd0, rev});
      write_reg(CSR_DEBOUNCE, {8'd0, deb});
      write_reg(CSR_LONG_PRESS, lp);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // let the backlog and all readouts clear, then the pipeline settle
   task automatic drain();
      while (word_backlog.size() != 0 || drv_have || queued_readouts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_tick(input logic [1:0] st, input logic btn);
      item_type w;
      w.kind = KIND_TICK;
      w.phase_a = st[0];
      w.phase_b = st[1];
      w.button_down = btn;
      w.skip_scroll = 1'($urandom_range(0, 1));
      word_backlog.push_back(w);
   endtask

   task automatic queue_access(input logic [2:0] k, input logic skip);
      item_type w;
      w.kind = k;
      w.phase_a = 1'($urandom_range(0, 1));
      w.phase_b = 1'($urandom_range(0, 1));
      w.button_down = 1'($urandom_range(0, 1));
      w.skip_scroll = skip;
      word_backlog.push_back(w);
   endtask

   task automatic add_spin(input int detents, input bit fwd);
      for (int i = 0; i < detents * 4; i++) begin
         gen_pos = (gen_pos + (fwd ? 1 : 3)) % 4;
         queue_tick(phase_at_place(gen_pos), 1'b0);
      end
   endtask

   task automatic add_mixed(input int n, input int deb, input int lp);
      int         made;
      int         r;
      int         move;
      int         cap;
      logic [6:0] raw;
      made = 0;
      cap = (lp < 60) ? lp + 4 : 60;
      while (made < n) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            raw = 7'($urandom);
            word_backlog.push_back(raw);
            if (raw[6:4] <= KIND_ACTION) made++;
         end else if (r < 30) begin
            queue_access(3'($urandom_range(KIND_FETCH, KIND_ACTION)),
                         1'($urandom_range(0, 1)));
            made++;
         end else begin
            if (gen_run == 0) begin
               gen_btn = !gen_btn;
               if (gen_btn) begin
                  case ($urandom_range(0, 3))
                     0: gen_run = $urandom_range(1, deb);
                     1: gen_run = deb + $urandom_range(1, 4);
                     default: gen_run = deb + $urandom_range(1, cap);
                  endcase
               end else begin
                  gen_run = $urandom_range(1, 12);
               end
            end
            gen_run--;
            if ($urandom_range(0, 49) == 0) gen_fwd = !gen_fwd;
            move = $urandom_range(0, 19);
            if (move < 12) begin
               gen_pos = (gen_pos + (gen_fwd ? 1 : 3)) % 4;
               queue_tick(phase_at_place(gen_pos), gen_btn);
            end else if (move < 14) begin
               gen_pos = (gen_pos + (gen_fwd ? 3 : 1)) % 4;
               queue_tick(phase_at_place(gen_pos), gen_btn);
            end else if (move == 14) begin
               queue_tick(phase_at_place(gen_pos + 2), gen_btn);
            end else begin
               queue_tick(phase_at_place(gen_pos), gen_btn);
            end
            made++;
         end
      end
   endtask

   task automatic run_mixed(input logic rev, input int deb, input int lp, input int n);
      set_config(rev, 8'(deb), 16'(lp));
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      add_mixed(n, deb, lp);
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed words with debounce 2 and long press 3
      set_config(1'b0, 8'd2, 16'd3);
      queue_access(KIND_FETCH, 1'b0);
      queue_access(KIND_QUERY, 1'b0);
      queue_access(KIND_ACTION, 1'b0);
      queue_tick(2'b01, 1'b0);
      queue_tick(PH_ZERO, 1'b0);
      queue_tick(2'b10, 1'b0);
      queue_tick(PH_THREE, 1'b0);
      // jump across two places is ignored
      queue_tick(PH_ZERO, 1'b0);
      queue_access(KIND_FETCH, 1'b0);
      queue_tick(2'b10, 1'b0);
      queue_tick(PH_ZERO, 1'b0);
      queue_tick(2'b01, 1'b0);
      queue_tick(PH_THREE, 1'b0);
      queue_access(KIND_ACTION, 1'b1);
      queue_access(KIND_ACTION, 1'b0);
      repeat (3) queue_tick(PH_THREE, 1'b1);
      queue_access(KIND_QUERY, 1'b0);
      queue_tick(PH_THREE, 1'b0);
      queue_access(KIND_ACTION, 1'b0);
      for (int k = KIND_ACTION + 1; k < 8; k++) begin
         word_backlog.push_back({3'(k), 4'b1111});
      end
      queue_access(KIND_CLEAR, 1'b1);
      drain();

      run_mixed(1'b1, 1, 1, 120);
      run_mixed(1'b0, 4, 12, 120);

      // detent saturation both ways
      set_config(1'b1, 8'd3, 16'd20);
      calm_send = 1'b0;
      calm_recv = 1'b0;
      add_spin(130, 1'b1);
      queue_access(KIND_FETCH, 1'b0);
      add_spin(130, 1'b0);
      queue_access(KIND_ACTION, 1'b0);
      drain();

      run_mixed(1'b1, 254, 300, 100);
      run_mixed(1'b0, 7, 65535, 100);

      // press counter saturates
      set_config(1'b0, 8'd255, 16'd65534);
      calm_send = 1'b1;
      calm_recv = 1'b1;
      queue_tick(phase_at_place(gen_pos), 1'b0);
      queue_access(KIND_CLEAR, 1'b0);
      repeat (260) queue_tick(phase_at_place(gen_pos), 1'b1);
      queue_access(KIND_QUERY, 1'b0);
      queue_access(KIND_QUERY, 1'b0);
      queue_tick(phase_at_place(gen_pos), 1'b1);
      queue_access(KIND_QUERY, 1'b0);
      queue_access(KIND_ACTION, 1'b1);
      queue_tick(phase_at_place(gen_pos), 1'b0);
      queue_access(KIND_QUERY, 1'b0);
      gen_btn = 1'b0;
      gen_run = 0;
      drain();

      run_mixed(1'b1, 50, 1000, 100);

      $display("run covered %0d words over %0d register settings, %0d readout words compared",
               words_sent, settings_used, readouts_seen);
      $display("incl. detent saturation, press counter saturation, unknown kinds");
      if (failures == 0 && queued_readouts.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
